// ===== hdl/ddk_pkg.sv =====
package ddk_pkg;

    localparam int SPR_FRAC   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_BITS   = 32;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_TRACK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_PER_SPEED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_PER_RPM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_TRACK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RPM       = 3'd4;

    typedef struct packed {
        logic [23:0] half_track;
        logic [31:0] rpm_per_speed;
        logic [23:0] speed_per_rpm;
        logic [23:0] inv_track;
        logic [30:0] max_rpm;
    } t_cfg;

    typedef struct packed {
        logic        func;
        logic        sat;
        logic        neg_l;
        logic        neg_r;
        logic [31:0] lo_n;
        logic [31:0] ro_n;
        logic [31:0] speed;
        logic [31:0] turn;
        logic [31:0] pv;
    } t_side;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] wq;
    } t_lane;

    function automatic logic [31:0] mag32(input logic [31:0] a);
        return a[31] ? (~a + 32'd1) : a;
    endfunction

endpackage

// ===== hdl/diff_drive_kinematics_desat_top.sv =====
// Channel   Handshake            Payload
// input     i_valid / o_ready    i_func, i_cmd_speed, i_cmd_turn_rate, i_left_rpm, i_right_rpm
// output    o_valid / i_ready    o_left_rpm_out, o_right_rpm_out, o_speed_out,
//                                o_turn_rate_out, o_status
// config    i_cfg_wr_en          i_cfg_addr, i_cfg_wr_data
//
// One item enters per cycle unless the output stalls. Stages: five kinematics, sixteen of
// the desaturation divider at two quotient bits each, and the output register.
// Reset clears all valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline, so no item is lost or repeated.
module diff_drive_kinematics_desat_top
    import ddk_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [31:0]          i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_func,
    input  logic signed [31:0]   i_cmd_speed,
    input  logic signed [31:0]   i_cmd_turn_rate,
    input  logic signed [31:0]   i_left_rpm,
    input  logic signed [31:0]   i_right_rpm,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_left_rpm_out,
    output logic signed [31:0]   o_right_rpm_out,
    output logic signed [31:0]   o_speed_out,
    output logic signed [31:0]   o_turn_rate_out,
    output logic                 o_status
);

    t_cfg r_cfg;
    logic w_en;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_track    <= 24'd6554;
            r_cfg.rpm_per_speed <= 32'd18966000;
            r_cfg.speed_per_rpm <= 24'd57979;
            r_cfg.inv_track     <= 24'd327680;
            r_cfg.max_rpm       <= 31'd19660800;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_HALF_TRACK:    r_cfg.half_track    <= i_cfg_wr_data[23:0];
                CFG_RPM_PER_SPEED: r_cfg.rpm_per_speed <= i_cfg_wr_data;
                CFG_SPEED_PER_RPM: r_cfg.speed_per_rpm <= i_cfg_wr_data[23:0];
                CFG_INV_TRACK:     r_cfg.inv_track     <= i_cfg_wr_data[23:0];
                CFG_MAX_RPM:       r_cfg.max_rpm       <= i_cfg_wr_data[30:0];
                default: begin
                end
            endcase
        end
    end

    logic  w_vld  [DIV_STAGES+1];
    t_side w_side [DIV_STAGES+1];
    t_lane w_ll   [DIV_STAGES+1];
    t_lane w_lr   [DIV_STAGES+1];

    ddk_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_valid),
        .i_cfg          (r_cfg),
        .i_func         (i_func),
        .i_cmd_speed    (i_cmd_speed),
        .i_cmd_turn_rate(i_cmd_turn_rate),
        .i_left_rpm     (i_left_rpm),
        .i_right_rpm    (i_right_rpm),
        .o_valid        (w_vld[0]),
        .o_side         (w_side[0]),
        .o_lane_l       (w_ll[0]),
        .o_lane_r       (w_lr[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        ddk_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[g]),
            .i_side  (w_side[g]),
            .i_lane_l(w_ll[g]),
            .i_lane_r(w_lr[g]),
            .o_valid (w_vld[g+1]),
            .o_side  (w_side[g+1]),
            .o_lane_l(w_ll[g+1]),
            .o_lane_r(w_lr[g+1])
        );
    end

    t_side w_last;
    logic [31:0] w_ql, w_qr;

    assign w_last = w_side[DIV_STAGES];
    assign w_ql   = w_last.neg_l ? (~w_ll[DIV_STAGES].wq + 32'd1) : w_ll[DIV_STAGES].wq;
    assign w_qr   = w_last.neg_r ? (~w_lr[DIV_STAGES].wq + 32'd1) : w_lr[DIV_STAGES].wq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= w_vld[DIV_STAGES];
        end
        if (w_en) begin
            if (w_last.func) begin
                o_left_rpm_out  <= '0;
                o_right_rpm_out <= '0;
                o_speed_out     <= w_last.speed;
                o_turn_rate_out <= w_last.turn;
                o_status        <= 1'b0;
            end else begin
                o_left_rpm_out  <= w_last.sat ? w_ql : w_last.lo_n;
                o_right_rpm_out <= w_last.sat ? w_qr : w_last.ro_n;
                o_speed_out     <= '0;
                o_turn_rate_out <= '0;
                o_status        <= w_last.sat;
            end
        end
    end

endmodule

// ===== hdl/ddk_front.sv =====
module ddk_front
    import ddk_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_cfg        i_cfg,
    input  logic        i_func,
    input  logic [31:0] i_cmd_speed,
    input  logic [31:0] i_cmd_turn_rate,
    input  logic [31:0] i_left_rpm,
    input  logic [31:0] i_right_rpm,
    output logic        o_valid,
    output t_side       o_side,
    output t_lane       o_lane_l,
    output t_lane       o_lane_r
);

    localparam int LW = 60;

    function automatic logic [31:0] sat32(input logic [LW-1:0] x);
        if ((x[LW-1:31] == '0) || (x[LW-1:31] == '1)) begin
            return x[31:0];
        end
        return x[LW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    // Stage A
    logic        r_a_vld, r_a_func, r_a_wneg, r_a_lneg, r_a_rneg;
    logic [31:0] r_a_v;
    logic [55:0] r_a_dprod, r_a_pl, r_a_pr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
        if (i_en) begin
            r_a_func  <= i_func;
            r_a_v     <= i_cmd_speed;
            r_a_wneg  <= i_cmd_turn_rate[31];
            r_a_lneg  <= i_left_rpm[31];
            r_a_rneg  <= i_right_rpm[31];
            r_a_dprod <= {24'd0, mag32(i_cmd_turn_rate)} * {32'd0, i_cfg.half_track};
            r_a_pl    <= {24'd0, mag32(i_left_rpm)} * {32'd0, i_cfg.speed_per_rpm};
            r_a_pr    <= {24'd0, mag32(i_right_rpm)} * {32'd0, i_cfg.speed_per_rpm};
        end
    end

    // Stage B
    logic [56:0]   n_b_dsum, n_b_lsum, n_b_rsum;
    logic [LW-1:0] n_b_dext, n_b_sd, n_b_vext, n_b_vl, n_b_vr;
    logic [34:0]   n_b_sl, n_b_sr, n_b_s, n_b_d;

    always_comb begin
        n_b_dsum = {1'b0, r_a_dprod} + (57'd1 << (FRAC_BITS - 1));
        n_b_dext = LW'(n_b_dsum >> FRAC_BITS);
        n_b_sd   = r_a_wneg ? (~n_b_dext + LW'(1)) : n_b_dext;
        n_b_vext = {{(LW-32){r_a_v[31]}}, r_a_v};
        n_b_vl   = n_b_vext - n_b_sd;
        n_b_vr   = n_b_vext + n_b_sd;
        n_b_lsum = {1'b0, r_a_pl} + (57'd1 << (SPR_FRAC - 1));
        n_b_rsum = {1'b0, r_a_pr} + (57'd1 << (SPR_FRAC - 1));
        n_b_sl   = {2'd0, n_b_lsum[56:SPR_FRAC]};
        n_b_sr   = {2'd0, n_b_rsum[56:SPR_FRAC]};
        if (r_a_lneg) n_b_sl = ~n_b_sl + 35'd1;
        if (r_a_rneg) n_b_sr = ~n_b_sr + 35'd1;
        n_b_s = n_b_sl + n_b_sr;
        n_b_d = n_b_sr - n_b_sl;
    end

    logic        r_b_vld, r_b_func, r_b_sneg, r_b_dneg;
    logic [31:0] r_b_vl, r_b_vr;
    logic [33:0] r_b_smag, r_b_dmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
        if (i_en) begin
            r_b_func <= r_a_func;
            r_b_vl   <= sat32(n_b_vl);
            r_b_vr   <= sat32(n_b_vr);
            r_b_sneg <= n_b_s[34];
            r_b_dneg <= n_b_d[34];
            r_b_smag <= n_b_s[34] ? 34'(~n_b_s + 35'd1) : n_b_s[33:0];
            r_b_dmag <= n_b_d[34] ? 34'(~n_b_d + 35'd1) : n_b_d[33:0];
        end
    end

    // Stage C
    logic [31:0] n_c_al, n_c_ar;
    logic [34:0] n_c_ssum;
    logic [32:0] n_c_sm;
    logic [31:0] n_c_speed;

    always_comb begin
        n_c_al   = mag32(r_b_vl);
        n_c_ar   = mag32(r_b_vr);
        n_c_ssum = {1'b0, r_b_smag} + 35'd1;
        n_c_sm   = n_c_ssum[33:1];
        if (r_b_sneg) begin
            n_c_speed = (|n_c_sm[32:31]) ? 32'h8000_0000 : (~n_c_sm[31:0] + 32'd1);
        end else begin
            n_c_speed = (|n_c_sm[32:31]) ? 32'h7FFF_FFFF : n_c_sm[31:0];
        end
    end

    logic        r_c_vld, r_c_func, r_c_nl, r_c_nr, r_c_dneg;
    logic [63:0] r_c_pl, r_c_pr;
    logic [31:0] r_c_al, r_c_ar, r_c_pv, r_c_speed;
    logic [57:0] r_c_tprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_b_vld;
        end
        if (i_en) begin
            r_c_func  <= r_b_func;
            r_c_nl    <= r_b_vl[31];
            r_c_nr    <= r_b_vr[31];
            r_c_dneg  <= r_b_dneg;
            r_c_al    <= n_c_al;
            r_c_ar    <= n_c_ar;
            r_c_pv    <= (n_c_al > n_c_ar) ? n_c_al : n_c_ar;
            r_c_pl    <= {32'd0, n_c_al} * {32'd0, i_cfg.rpm_per_speed};
            r_c_pr    <= {32'd0, n_c_ar} * {32'd0, i_cfg.rpm_per_speed};
            r_c_tprod <= {24'd0, r_b_dmag} * {34'd0, i_cfg.inv_track};
            r_c_speed <= n_c_speed;
        end
    end

    // Stage D
    logic [64:0]   n_d_ml, n_d_mr, n_d_peak;
    logic [58:0]   n_d_tsum;
    logic [LW-1:0] n_d_text, n_d_tsig;

    always_comb begin
        n_d_ml   = ({1'b0, r_c_pl} + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        n_d_mr   = ({1'b0, r_c_pr} + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        n_d_peak = (n_d_ml > n_d_mr) ? n_d_ml : n_d_mr;
        n_d_tsum = {1'b0, r_c_tprod} + (59'd1 << (FRAC_BITS - 1));
        n_d_text = LW'(n_d_tsum >> FRAC_BITS);
        n_d_tsig = r_c_dneg ? (~n_d_text + LW'(1)) : n_d_text;
    end

    logic        r_d_vld, r_d_func, r_d_nl, r_d_nr, r_d_sat;
    logic [62:0] r_d_pnl, r_d_pnr;
    logic [31:0] r_d_pv, r_d_lo, r_d_ro, r_d_speed, r_d_turn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_d_vld <= r_c_vld;
        end
        if (i_en) begin
            r_d_func  <= r_c_func;
            r_d_nl    <= r_c_nl;
            r_d_nr    <= r_c_nr;
            r_d_sat   <= n_d_peak > {34'd0, i_cfg.max_rpm};
            r_d_lo    <= r_c_nl ? (~n_d_ml[31:0] + 32'd1) : n_d_ml[31:0];
            r_d_ro    <= r_c_nr ? (~n_d_mr[31:0] + 32'd1) : n_d_mr[31:0];
            r_d_pnl   <= {31'd0, r_c_al} * {32'd0, i_cfg.max_rpm};
            r_d_pnr   <= {31'd0, r_c_ar} * {32'd0, i_cfg.max_rpm};
            r_d_pv    <= r_c_pv;
            r_d_speed <= r_c_speed;
            r_d_turn  <= sat32(n_d_tsig);
        end
    end

    // Stage E
    logic [62:0] n_e_nl, n_e_nr;

    always_comb begin
        n_e_nl = r_d_pnl + {32'd0, r_d_pv[31:1]};
        n_e_nr = r_d_pnr + {32'd0, r_d_pv[31:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_d_vld;
        end
        if (i_en) begin
            o_side.func  <= r_d_func;
            o_side.sat   <= r_d_sat;
            o_side.neg_l <= r_d_nl;
            o_side.neg_r <= r_d_nr;
            o_side.lo_n  <= r_d_lo;
            o_side.ro_n  <= r_d_ro;
            o_side.speed <= r_d_speed;
            o_side.turn  <= r_d_turn;
            o_side.pv    <= r_d_pv;
            o_lane_l.rem <= {1'b0, n_e_nl[62:32]};
            o_lane_l.wq  <= n_e_nl[31:0];
            o_lane_r.rem <= {1'b0, n_e_nr[62:32]};
            o_lane_r.wq  <= n_e_nr[31:0];
        end
    end

endmodule

// ===== hdl/ddk_div_stage.sv =====
module ddk_div_stage
    import ddk_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_side i_side,
    input  t_lane i_lane_l,
    input  t_lane i_lane_r,
    output logic  o_valid,
    output t_side o_side,
    output t_lane o_lane_l,
    output t_lane o_lane_r
);

    function automatic t_lane div_step(input t_lane a, input logic [31:0] d);
        t_lane       x;
        logic [32:0] r2;
        x = a;
        for (int k = 0; k < DIV_STEP; k++) begin
            r2   = {x.rem, x.wq[31]};
            x.wq = {x.wq[30:0], 1'b0};
            if (r2 >= {1'b0, d}) begin
                r2      = r2 - {1'b0, d};
                x.wq[0] = 1'b1;
            end
            x.rem = r2[31:0];
        end
        return x;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_side   <= i_side;
            o_lane_l <= div_step(i_lane_l, i_side.pv);
            o_lane_r <= div_step(i_lane_r, i_side.pv);
        end
    end

endmodule

// ===== verif/ddk_checker.sv =====
`timescale 1ns / 1ps

module ddk_checker
    import ddk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic        i_func,
    input  logic [31:0] i_cmd_speed,
    input  logic [31:0] i_cmd_turn_rate,
    input  logic [31:0] i_left_rpm,
    input  logic [31:0] i_right_rpm,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [31:0] o_left_rpm_out,
    input  logic [31:0] o_right_rpm_out,
    input  logic [31:0] o_speed_out,
    input  logic [31:0] o_turn_rate_out,
    input  logic        o_status,
    output int          errors,
    output int          pending,
    output int          n_results,
    output int          n_desat
);

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] speed;
        logic [31:0] turn;
        logic        st;
    } t_wheels;

    t_cfg    regs;
    t_wheels wheel_q[$];

    assign pending = wheel_q.size();

    function automatic logic [63:0] mag(input logic signed [63:0] a);
        return a < 0 ? -a : a;
    endfunction

    function automatic logic signed [63:0] rmul(input logic signed [63:0] a,
                                                input logic [63:0] b, input int sh);
        logic [63:0] m;
        m = (mag(a) * b + (64'd1 << (sh - 1))) >> sh;
        return a < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] sat(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic t_wheels kinematics(input logic f, input logic [31:0] v32,
                                           input logic [31:0] w32, input logic [31:0] l32,
                                           input logic [31:0] r32);
        t_wheels res;
        logic signed [63:0] v, w, dif, vl, vr, lo, ro;
        logic [63:0] ml, mr, pk, al, ar, pv;
        res = '0;
        if (!f) begin
            v = $signed(v32);
            w = $signed(w32);
            dif = rmul(w, regs.half_track, 16);
            vl = sat(v - dif);
            vr = sat(v + dif);
            ml = (mag(vl) * regs.rpm_per_speed + 64'd32768) >> 16;
            mr = (mag(vr) * regs.rpm_per_speed + 64'd32768) >> 16;
            pk = ml > mr ? ml : mr;
            if (pk <= regs.max_rpm) begin
                lo = vl < 0 ? -$signed(ml) : $signed(ml);
                ro = vr < 0 ? -$signed(mr) : $signed(mr);
            end else begin
                al = mag(vl);
                ar = mag(vr);
                pv = al > ar ? al : ar;
                if (pv == 0) pv = 1;
                lo = (al * regs.max_rpm + pv / 2) / pv;
                ro = (ar * regs.max_rpm + pv / 2) / pv;
                if (vl < 0) lo = -lo;
                if (vr < 0) ro = -ro;
                res.st = 1'b1;
            end
            res.left = lo[31:0];
            res.right = ro[31:0];
        end else begin
            vl = rmul($signed(l32), regs.speed_per_rpm, SPR_FRAC);
            vr = rmul($signed(r32), regs.speed_per_rpm, SPR_FRAC);
            lo = sat(rmul(vl + vr, 1, 1));
            ro = sat(rmul(vr - vl, regs.inv_track, 16));
            res.speed = lo[31:0];
            res.turn = ro[31:0];
        end
        return res;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial begin
        errors = 0;
        n_results = 0;
        n_desat = 0;
    end

    always @(posedge i_clk) begin
        t_wheels want;
        if (!i_rst_n) begin
            regs.half_track <= 24'd6554;
            regs.rpm_per_speed <= 32'd18966000;
            regs.speed_per_rpm <= 24'd57979;
            regs.inv_track <= 24'd327680;
            regs.max_rpm <= 31'd19660800;
        end else begin
            if (i_valid && o_ready)
                wheel_q.push_back(kinematics(i_func, i_cmd_speed, i_cmd_turn_rate,
                                             i_left_rpm, i_right_rpm));
            if (o_valid && i_ready) begin
                n_results++;
                if (wheel_q.size() == 0) begin
                    report("unexpected item", 0, 0);
                end else begin
                    want = wheel_q.pop_front();
                    if (want.st) n_desat++;
                    if (o_left_rpm_out !== want.left) report("left", o_left_rpm_out, want.left);
                    if (o_right_rpm_out !== want.right)
                        report("right", o_right_rpm_out, want.right);
                    if (o_speed_out !== want.speed) report("speed", o_speed_out, want.speed);
                    if (o_turn_rate_out !== want.turn)
                        report("turn", o_turn_rate_out, want.turn);
                    if (o_status !== want.st) report("status", o_status, want.st);
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_HALF_TRACK:    regs.half_track <= i_cfg_wr_data[23:0];
                    CFG_RPM_PER_SPEED: regs.rpm_per_speed <= i_cfg_wr_data;
                    CFG_SPEED_PER_RPM: regs.speed_per_rpm <= i_cfg_wr_data[23:0];
                    CFG_INV_TRACK:     regs.inv_track <= i_cfg_wr_data[23:0];
                    CFG_MAX_RPM:       regs.max_rpm <= i_cfg_wr_data[30:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ddk_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_func = 1'b0;
    logic [31:0] i_cmd_speed = '0, i_cmd_turn_rate = '0, i_left_rpm = '0, i_right_rpm = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_left_rpm_out, o_right_rpm_out, o_speed_out, o_turn_rate_out;
    logic        o_status;
    int          errors, pending, n_results, n_desat;
    bit          hold_off = 1'b0;
    bit          done = 1'b0;

    always #4 i_clk = ~i_clk;

    diff_drive_kinematics_desat_top dut (.*);

    ddk_checker checker_i (.*);

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    function automatic logic [31:0] pick();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'h0 : 32'hffffffff;
            3: return $signed($urandom_range(0, 2000000)) - 1000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input logic f, input logic [31:0] a, input logic [31:0] b);
        i_valid <= 1'b1;
        i_func <= f;
        i_cmd_speed <= a;
        i_cmd_turn_rate <= b;
        i_left_rpm <= a;
        i_right_rpm <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wr_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic random_items(input int n);
        int k;
        int g;
        for (k = 0; k < n; k++) begin
            send($urandom_range(0, 1), pick(), pick());
            if ($urandom_range(0, 2) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    i_valid <= 1'b0;
                    repeat (g) @(negedge i_clk);
                end
            end
        end
        i_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (hold_off) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(0, 3) != 0);
    end

    initial begin
        int k;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send(0, 32'h0, 32'h0);
        send(0, 32'h10000, 32'h0);
        send(0, 32'h10000, 32'h10000);
        send(0, 32'h7fffffff, 32'h7fffffff);
        send(0, 32'h80000000, 32'h7fffffff);
        send(0, 32'h80000000, 32'h80000000);
        send(0, 32'hfff00000, 32'h00030000);
        send(1, 32'h0, 32'h0);
        send(1, 32'h7fffffff, 32'h80000000);
        send(1, 32'h80000000, 32'h80000000);
        send(1, 32'h7fffffff, 32'h7fffffff);
        send(1, 32'h00640000, 32'hff9c0000);
        i_valid <= 1'b0;
        drain();
        random_items(150);
        drain();
        cfg_write(CFG_HALF_TRACK, 32'hffffff);
        cfg_write(CFG_RPM_PER_SPEED, 32'hffffffff);
        cfg_write(CFG_SPEED_PER_RPM, 32'hffffff);
        cfg_write(CFG_INV_TRACK, 32'hffffff);
        cfg_write(CFG_MAX_RPM, 32'h7fffffff);
        random_items(150);
        drain();
        cfg_write(CFG_HALF_TRACK, 32'd1);
        cfg_write(CFG_RPM_PER_SPEED, 32'd1);
        cfg_write(CFG_SPEED_PER_RPM, 32'd1);
        cfg_write(CFG_INV_TRACK, 32'd1);
        cfg_write(CFG_MAX_RPM, 32'd1);
        random_items(150);
        drain();
        for (k = 0; k < 5; k++) cfg_write(k[CFG_IDX_W-1:0], $urandom & 32'h00ffffff);
        hold_off = 1'b1;
        fork
            random_items(100);
            begin
                repeat (200) @(negedge i_clk);
                hold_off = 1'b0;
            end
        join
        drain();
        cfg_write(CFG_MAX_RPM, 32'd0);
        random_items(150);
        drain();
        $display("Covered %0d results, %0d of them desaturated, over five register settings.",
                 n_results, n_desat);
        if (errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        done = 1'b1;
        $finish;
    end

    initial begin
        #2000000;
        if (!done) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
